[sv/tse_pkg.sv]
// Shared types and constants for the TLS server-name extractor.
// Used by tse_front, tse_parser and tls_sni_extract; depends on nothing.
package tse_pkg;

  // Width of the saturating byte offset counter
  localparam int OFFSET_BITS = 17;
  // Width of record end and field skip counters
  localparam int LEN_BITS    = 17;

  localparam logic [7:0] CONTENT_HANDSHAKE = 8'h16;
  localparam logic [7:0] HS_CLIENT_HELLO   = 8'h01;
  localparam logic [7:0] MIN_MAJOR_VERSION = 8'h03;
  // Record header is 5 bytes, then handshake type, length, version, random
  localparam int RECORD_HEADER_BYTES = 5;
  localparam int FIXED_BYTES         = 38;
  localparam int FIXED_LAST_OFFSET   = RECORD_HEADER_BYTES + FIXED_BYTES - 1;
  localparam int EXT_HEADER_BYTES    = 4;
  localparam int SNI_LIST_HEAD_BYTES = 3;
  localparam int LEN_FIELD_BYTES     = 2;

  // Register indexes
  localparam logic REG_MAX_NAME_LENGTH = 1'b0;

  typedef enum logic [3:0] {
    PH_HEAD      = 4'd0,
    PH_FIXED     = 4'd1,
    PH_SID_LEN   = 4'd2,
    PH_SID_BODY  = 4'd3,
    PH_CS_LEN_HI = 4'd4,
    PH_CS_LEN_LO = 4'd5,
    PH_CS_BODY   = 4'd6,
    PH_CM_LEN    = 4'd7,
    PH_CM_BODY   = 4'd8,
    PH_EXTS_LEN  = 4'd9,
    PH_EXT_HEAD  = 4'd10,
    PH_EXT_BODY  = 4'd11,
    PH_SNI_HEAD  = 4'd12,
    PH_NAME_LEN  = 4'd13,
    PH_NAME      = 4'd14
  } phase_t;

  // One classified input item as held in the queue
  typedef struct packed {
    logic       is_zero;
    logic       start;
    logic [7:0] data;
  } item_t;

endpackage

[sv/tse_front.sv]
// Input side of the extractor: accepts bytes, tags zero bytes and queues them.
// Depends on tse_pkg.
module tse_front import tse_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data,
  input  logic        in_start,
  output logic        q_valid,
  input  logic        q_pop,
  output item_t       q_item
);

  item_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != 2'd0);
  assign q_item   = slots[rd_ptr];

  // Store the classified item
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= '{is_zero: (in_data == 8'd0), start: in_start, data: in_data};
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      case ({push, q_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

[sv/tse_parser.sv]
// Back end of the extractor: ClientHello walk and result output register.
// Depends on tse_pkg; fed by tse_front.
module tse_parser import tse_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  max_name_length,
  input  logic        q_valid,
  output logic        q_pop,
  input  item_t       q_item,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_name_byte,
  output logic        out_rejected,
  output logic        out_last
);

  localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;

  phase_t                 phase, phase_next;
  logic [OFFSET_BITS-1:0] byte_offset, byte_offset_next;
  logic [LEN_BITS-1:0]    record_end, record_end_next;
  logic [LEN_BITS-1:0]    skip_remaining, skip_remaining_next;
  logic [7:0]             length_high_byte, length_high_byte_next;
  logic                   extension_is_name, extension_is_name_next;
  logic [7:0]             name_remaining, name_remaining_next;
  logic                   finished, finished_next;

  logic                   emit;
  logic [7:0]             emit_byte;
  logic                   emit_rejected;
  logic                   emit_last;

  // Take an item whenever the output register is free or draining
  assign q_pop = q_valid && (!out_valid || out_ready);

  // Next parser state for the byte at the head of the queue
  always_comb begin
    logic [7:0]             b;
    logic [OFFSET_BITS-1:0] pos;
    logic [15:0]            len16;
    logic [2:0]             idx;
    logic                   reject;
    b     = q_item.data;
    phase_next             = phase;
    byte_offset_next       = byte_offset;
    record_end_next        = record_end;
    skip_remaining_next    = skip_remaining;
    length_high_byte_next  = length_high_byte;
    extension_is_name_next = extension_is_name;
    name_remaining_next    = name_remaining;
    finished_next          = finished;
    emit          = 1'b0;
    emit_byte     = 8'd0;
    emit_rejected = 1'b0;
    emit_last     = 1'b0;
    reject        = 1'b0;
    if (q_item.start) begin
      phase_next             = PH_HEAD;
      byte_offset_next       = '0;
      record_end_next        = '0;
      skip_remaining_next    = '0;
      length_high_byte_next  = 8'd0;
      extension_is_name_next = 1'b0;
      name_remaining_next    = 8'd0;
      finished_next          = 1'b0;
    end
    pos   = byte_offset_next;
    len16 = {length_high_byte_next, b};
    idx   = 3'(EXT_HEADER_BYTES) - skip_remaining_next[2:0];
    if (!finished_next) begin
      case (phase_next)
        PH_HEAD: begin
          if (pos == OFFSET_BITS'(0) && b != CONTENT_HANDSHAKE) reject = 1'b1;
          if (pos == OFFSET_BITS'(1) && b < MIN_MAJOR_VERSION) reject = 1'b1;
          if (pos == OFFSET_BITS'(3)) length_high_byte_next = b;
          if (pos == OFFSET_BITS'(4)) begin
            record_end_next = LEN_BITS'(len16) + LEN_BITS'(RECORD_HEADER_BYTES);
            phase_next = PH_FIXED;
          end
        end
        PH_FIXED: begin
          if (pos == OFFSET_BITS'(RECORD_HEADER_BYTES) && b != HS_CLIENT_HELLO) begin
            reject = 1'b1;
          end
          if (pos >= OFFSET_BITS'(FIXED_LAST_OFFSET)) phase_next = PH_SID_LEN;
        end
        PH_SID_LEN: begin
          skip_remaining_next = LEN_BITS'(b);
          phase_next = q_item.is_zero ? PH_CS_LEN_HI : PH_SID_BODY;
        end
        PH_CS_LEN_HI: begin
          length_high_byte_next = b;
          phase_next = PH_CS_LEN_LO;
        end
        PH_CS_LEN_LO: begin
          skip_remaining_next = LEN_BITS'(len16);
          phase_next = (len16 == 16'd0) ? PH_CM_LEN : PH_CS_BODY;
        end
        PH_CM_LEN: begin
          if (q_item.is_zero) begin
            phase_next = PH_EXTS_LEN;
            skip_remaining_next = LEN_BITS'(LEN_FIELD_BYTES);
          end else begin
            phase_next = PH_CM_BODY;
            skip_remaining_next = LEN_BITS'(b);
          end
        end
        PH_SID_BODY, PH_CS_BODY, PH_CM_BODY, PH_EXTS_LEN, PH_EXT_BODY,
        PH_SNI_HEAD: begin
          if (skip_remaining_next != '0) begin
            skip_remaining_next = skip_remaining_next - LEN_BITS'(1);
          end
          if (skip_remaining_next == '0) begin
            case (phase_next)
              PH_SID_BODY: phase_next = PH_CS_LEN_HI;
              PH_CS_BODY:  phase_next = PH_CM_LEN;
              PH_CM_BODY: begin
                phase_next = PH_EXTS_LEN;
                skip_remaining_next = LEN_BITS'(LEN_FIELD_BYTES);
              end
              PH_SNI_HEAD: begin
                phase_next = PH_NAME_LEN;
                skip_remaining_next = LEN_BITS'(LEN_FIELD_BYTES);
              end
              default: begin
                phase_next = PH_EXT_HEAD;
                skip_remaining_next = LEN_BITS'(EXT_HEADER_BYTES);
              end
            endcase
          end
        end
        PH_EXT_HEAD: begin
          if (idx == 3'd0) begin
            // Whole extension header must fit before the record end
            if (({1'b0, pos} + (OFFSET_BITS+1)'(EXT_HEADER_BYTES)) >
                (OFFSET_BITS+1)'(record_end_next)) begin
              reject = 1'b1;
            end
            extension_is_name_next = q_item.is_zero;
          end else if (idx == 3'd1) begin
            extension_is_name_next = extension_is_name_next && q_item.is_zero;
          end else if (idx == 3'd2) begin
            length_high_byte_next = b;
          end
          if (skip_remaining_next != '0) begin
            skip_remaining_next = skip_remaining_next - LEN_BITS'(1);
          end
          if (idx >= 3'd3) begin
            if (extension_is_name_next) begin
              phase_next = PH_SNI_HEAD;
              skip_remaining_next = LEN_BITS'(SNI_LIST_HEAD_BYTES);
            end else if (len16 == 16'd0) begin
              phase_next = PH_EXT_HEAD;
              skip_remaining_next = LEN_BITS'(EXT_HEADER_BYTES);
            end else begin
              phase_next = PH_EXT_BODY;
              skip_remaining_next = LEN_BITS'(len16);
            end
          end
        end
        PH_NAME_LEN: begin
          if (skip_remaining_next >= LEN_BITS'(2)) begin
            // High byte of the name length must be zero
            if (!q_item.is_zero) reject = 1'b1;
            length_high_byte_next = b;
            skip_remaining_next = LEN_BITS'(1);
          end else begin
            if (q_item.is_zero || b > max_name_length) reject = 1'b1;
            name_remaining_next = b;
            skip_remaining_next = '0;
            phase_next = PH_NAME;
          end
        end
        PH_NAME: begin
          emit      = 1'b1;
          emit_byte = b;
          if (name_remaining_next != 8'd0) name_remaining_next = name_remaining_next - 8'd1;
          if (name_remaining_next == 8'd0) begin
            emit_last     = 1'b1;
            finished_next = 1'b1;
          end
        end
        default: reject = 1'b1;
      endcase
      if (reject) begin
        emit          = 1'b1;
        emit_byte     = 8'd0;
        emit_rejected = 1'b1;
        emit_last     = 1'b1;
        finished_next = 1'b1;
      end else if (byte_offset_next != OFFSET_MAX) begin
        byte_offset_next = byte_offset_next + OFFSET_BITS'(1);
      end
    end
  end

  // Parser state register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_HEAD;
      byte_offset       <= '0;
      record_end        <= '0;
      skip_remaining    <= '0;
      length_high_byte  <= 8'd0;
      extension_is_name <= 1'b0;
      name_remaining    <= 8'd0;
      finished          <= 1'b0;
    end else if (q_pop) begin
      phase             <= phase_next;
      byte_offset       <= byte_offset_next;
      record_end        <= record_end_next;
      skip_remaining    <= skip_remaining_next;
      length_high_byte  <= length_high_byte_next;
      extension_is_name <= extension_is_name_next;
      name_remaining    <= name_remaining_next;
      finished          <= finished_next;
    end
  end

  // Output register: load a result, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && emit) begin
      out_name_byte <= emit_byte;
      out_rejected  <= emit_rejected;
      out_last      <= emit_last;
    end
  end

endmodule

[sv/tls_sni_extract.sv]
// TLS server-name extractor: one byte in per cycle from the client stream
// while the output is not stalled; each byte passes a two-entry queue
// (tse_front) to the parser (tse_parser), whose state update and output
// register set the rate of one byte per clock, through the queue and then
// the output register. A byte with tuser set restarts parsing. Name bytes
// come out with tlast on the final one; a malformed hello, an oversized or
// empty name gives one result with tuser set, tdata zero and tlast high.
// After that, bytes are swallowed until the next restart. max_name_length
// sits at byte address 0 of the APB port and resets to 255.
module tls_sni_extract import tse_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic [0:0]  s_axis_tuser,   // [0] start_of_connection
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] name_byte
  output logic [0:0]  m_axis_tuser,   // [0] rejected
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0] max_name_length;
  logic       q_valid;
  logic       q_pop;
  item_t      q_item;
  logic       rejected;

  // Configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MAX_NAME_LENGTH) ? {24'd0, max_name_length} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_name_length <= 8'd255;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == REG_MAX_NAME_LENGTH) begin
      max_name_length <= pwdata[7:0];
    end
  end

  tse_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_data  (s_axis_tdata),
    .in_start (s_axis_tuser[0]),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_item   (q_item)
  );

  tse_parser u_parser (
    .clk             (clk),
    .rst             (rst),
    .max_name_length (max_name_length),
    .q_valid         (q_valid),
    .q_pop           (q_pop),
    .q_item          (q_item),
    .out_valid       (m_axis_tvalid),
    .out_ready       (m_axis_tready),
    .out_name_byte   (m_axis_tdata),
    .out_rejected    (rejected),
    .out_last        (m_axis_tlast)
  );

  assign m_axis_tuser = rejected;

endmodule
